// ===== rtl/core/dpodc_pkg.sv =====
// Shared types, constants and microcode table for the date period overlap block.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package dpodc_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 22;
   localparam int SERIAL_W = 23;
   localparam int YY_W     = 15;
   localparam int QUOT_W   = 9;
   localparam int PROD_W   = 30;
   localparam int PC_W     = 3;
   localparam int DATE_W   = 2;

   localparam logic [YY_W-1:0]    RECIP_100   = 15'd20972;
   localparam int                 RECIP_SHIFT = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   typedef struct packed {
      logic [YEAR_W-1:0]  first_start_year;
      logic [MONTH_W-1:0] first_start_month;
      logic [DAY_W-1:0]   first_start_day;
      logic [YEAR_W-1:0]  first_end_year;
      logic [MONTH_W-1:0] first_end_month;
      logic [DAY_W-1:0]   first_end_day;
      logic [YEAR_W-1:0]  second_start_year;
      logic [MONTH_W-1:0] second_start_month;
      logic [DAY_W-1:0]   second_start_day;
      logic [YEAR_W-1:0]  second_end_year;
      logic [MONTH_W-1:0] second_end_month;
      logic [DAY_W-1:0]   second_end_day;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] overlap_days;
      logic               bad_date;
   } rsp_type;

   typedef enum logic [2:0] {
      UOP_DIV_Y,
      UOP_CHECK,
      UOP_DIV_YY,
      UOP_SUM_A,
      UOP_SUM_B,
      UOP_RANGE,
      UOP_COUNT,
      UOP_FINISH
   } uop_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_NEXT_DATE,
      JC_BAD
   } jcond_type;

   typedef struct packed {
      uop_type          op;
      jcond_type        cond;
      logic [PC_W-1:0]  target;
   } ucode_word_type;

   typedef struct packed {
      logic              valid;
      logic              start;
      uop_type           op;
      logic [DATE_W-1:0] date;
   } dp_ctrl_type;

   typedef struct packed {
      logic bad;
   } dp_status_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   localparam logic [PC_W-1:0] PC_DATE_LOOP = 3'd0;
   localparam logic [PC_W-1:0] PC_FINISH    = 3'd7;

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{op: UOP_FINISH, cond: JC_NONE, target: PC_DATE_LOOP};
      unique case (pc)
         3'd0: w = '{op: UOP_DIV_Y,  cond: JC_NONE,      target: PC_DATE_LOOP};
         3'd1: w = '{op: UOP_CHECK,  cond: JC_NONE,      target: PC_DATE_LOOP};
         3'd2: w = '{op: UOP_DIV_YY, cond: JC_NONE,      target: PC_DATE_LOOP};
         3'd3: w = '{op: UOP_SUM_A,  cond: JC_NONE,      target: PC_DATE_LOOP};
         3'd4: w = '{op: UOP_SUM_B,  cond: JC_NEXT_DATE, target: PC_DATE_LOOP};
         3'd5: w = '{op: UOP_RANGE,  cond: JC_BAD,       target: PC_FINISH};
         3'd6: w = '{op: UOP_COUNT,  cond: JC_NONE,      target: PC_DATE_LOOP};
         3'd7: w = '{op: UOP_FINISH, cond: JC_NONE,      target: PC_DATE_LOOP};
         default: w = '{op: UOP_FINISH, cond: JC_NONE, target: PC_DATE_LOOP};
      endcase
      return w;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [8:0] off;
      unique case (month)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

// ===== rtl/core/date_period_overlap_day_count.sv =====
// Top level of the date period overlap counter: request register, sequencer, datapath
// and result register. Depends on dpodc_pkg, dpodc_useq and dpodc_dpath.
//
// The block takes one request holding two Gregorian date periods and returns the number
// of days that lie in both, ends included, with bad_date set and a zero count when any
// date is invalid. A request is taken only while the block is idle, and a new request can
// be taken in the same cycle that the result appears. The microcode program runs five
// steps per date, four times over one shared 15 by 15 bit reciprocal multiplier, then
// range, count and finish steps; when a date is bad the count step is skipped. A result
// that waits in the output register only holds the sequencer at its finish step.
module date_period_overlap_day_count (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dpodc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dpodc_pkg::rsp_type rsp_data
);

   dpodc_pkg::req_type       req_ff;
   dpodc_pkg::rsp_type       rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   dpodc_pkg::dp_ctrl_type   ctrl;
   dpodc_pkg::dp_status_type status;
   dpodc_pkg::rsp_type       result;
   logic                     busy;
   logic                     finish;
   logic                     accept;
   logic                     out_block;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign out_block = rsp_valid_ff && rsp_stall;

   dpodc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .out_block (out_block),
      .status    (status),
      .ctrl      (ctrl),
      .busy      (busy),
      .finish    (finish)
   );

   dpodc_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .req    (req_ff),
      .status (status),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (finish) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/dpodc_useq.sv =====
// Microcode sequencer: step counter, date loop counter and jump logic over the ROM.
// Depends on dpodc_pkg for the control word, the datapath control and status types.
module dpodc_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   out_block,
   input  dpodc_pkg::dp_status_type status,
   output dpodc_pkg::dp_ctrl_type ctrl,
   output logic                   busy,
   output logic                   finish
);

   dpodc_pkg::seq_state_type state_ff, state_in;
   logic [dpodc_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic [dpodc_pkg::DATE_W-1:0] date_ff, date_in;
   dpodc_pkg::ucode_word_type    word;
   logic                         jump;

   assign word = dpodc_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (word.cond)
         dpodc_pkg::JC_NEXT_DATE: jump = (date_ff != '1);
         dpodc_pkg::JC_BAD:       jump = status.bad;
         default:                 jump = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpodc_pkg::SEQ_IDLE: begin
            if (start) state_in = dpodc_pkg::SEQ_RUN;
         end
         dpodc_pkg::SEQ_RUN: begin
            if (word.op == dpodc_pkg::UOP_FINISH && !out_block) state_in = dpodc_pkg::SEQ_IDLE;
         end
         default: state_in = dpodc_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      date_in = date_ff;
      if (state_ff == dpodc_pkg::SEQ_IDLE) begin
         pc_in   = '0;
         date_in = '0;
      end else if (word.op == dpodc_pkg::UOP_FINISH) begin
         if (!out_block) pc_in = '0;
      end else if (jump) begin
         pc_in = word.target;
         if (word.cond == dpodc_pkg::JC_NEXT_DATE) date_in = date_ff + 1'b1;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_comb begin
      ctrl.valid = (state_ff == dpodc_pkg::SEQ_RUN);
      ctrl.start = start;
      ctrl.op    = word.op;
      ctrl.date  = date_ff;
      busy       = (state_ff == dpodc_pkg::SEQ_RUN);
      finish     = (state_ff == dpodc_pkg::SEQ_RUN) && (word.op == dpodc_pkg::UOP_FINISH)
                   && !out_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpodc_pkg::SEQ_IDLE;
         pc_ff    <= '0;
         date_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         date_ff  <= date_in;
      end
   end

endmodule

// ===== rtl/core/dpodc_dpath.sv =====
// Datapath: one shared reciprocal multiplier, date check, serial day sums and overlap count.
// Depends on dpodc_pkg for the request, result, control and status types and the tables.
module dpodc_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  dpodc_pkg::dp_ctrl_type   ctrl,
   input  dpodc_pkg::req_type       req,
   output dpodc_pkg::dp_status_type status,
   output dpodc_pkg::rsp_type       result
);

   logic [dpodc_pkg::YEAR_W-1:0]   year_sel;
   logic [dpodc_pkg::MONTH_W-1:0]  month_sel;
   logic [dpodc_pkg::DAY_W-1:0]    day_sel;
   logic [dpodc_pkg::YY_W-1:0]     mul_a;
   logic [dpodc_pkg::PROD_W-1:0]   product;
   logic [dpodc_pkg::YEAR_W-1:0]   q_times;
   logic [dpodc_pkg::YEAR_W-1:0]   rem_full;
   logic                           leap;
   logic [dpodc_pkg::DAY_W-1:0]    mlen;
   logic                           date_bad;
   logic [dpodc_pkg::SERIAL_W:0]   span;

   logic [dpodc_pkg::QUOT_W-1:0]   q_ff, q_in;
   logic [dpodc_pkg::YY_W-1:0]     yy_ff, yy_in;
   logic [dpodc_pkg::SERIAL_W-1:0] acc_ff, acc_in;
   logic [dpodc_pkg::SERIAL_W-1:0] serial_ff [4];
   logic [dpodc_pkg::SERIAL_W-1:0] serial_in;
   logic [dpodc_pkg::SERIAL_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                           ok_ff, ok_in;
   logic                           bad_ff, bad_in;
   logic [dpodc_pkg::COUNT_W-1:0]  count_ff, count_in;

   always_comb begin
      unique case (ctrl.date)
         2'd0: begin
            year_sel  = req.first_start_year;
            month_sel = req.first_start_month;
            day_sel   = req.first_start_day;
         end
         2'd1: begin
            year_sel  = req.first_end_year;
            month_sel = req.first_end_month;
            day_sel   = req.first_end_day;
         end
         2'd2: begin
            year_sel  = req.second_start_year;
            month_sel = req.second_start_month;
            day_sel   = req.second_start_day;
         end
         default: begin
            year_sel  = req.second_end_year;
            month_sel = req.second_end_month;
            day_sel   = req.second_end_day;
         end
      endcase
   end

   assign mul_a   = (ctrl.op == dpodc_pkg::UOP_DIV_YY) ? yy_ff
                                                       : dpodc_pkg::YY_W'(year_sel);
   assign product = dpodc_pkg::PROD_W'(mul_a) * dpodc_pkg::PROD_W'(dpodc_pkg::RECIP_100);

   assign q_times  = dpodc_pkg::YEAR_W'(q_ff) * 14'd100;
   assign rem_full = year_sel - q_times;
   assign leap     = (year_sel[1:0] == 2'd0) && ((rem_full[6:0] != 7'd0) || (q_ff[1:0] == 2'd0));
   assign mlen     = dpodc_pkg::month_len(month_sel, leap);
   assign date_bad = (day_sel == '0) || (day_sel > mlen);

   assign serial_in = acc_ff - dpodc_pkg::SERIAL_W'(q_ff) + dpodc_pkg::SERIAL_W'(q_ff >> 2)
                      + dpodc_pkg::SERIAL_W'(dpodc_pkg::month_offset(month_sel))
                      + dpodc_pkg::SERIAL_W'(day_sel);
   assign span      = {1'b0, hi_ff} - {1'b0, lo_ff} + 1'b1;

   always_comb begin
      q_in     = q_ff;
      yy_in    = yy_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      ok_in    = ok_ff;
      bad_in   = bad_ff;
      count_in = count_ff;
      if (ctrl.start) begin
         bad_in   = 1'b0;
         count_in = '0;
      end else if (ctrl.valid) begin
         unique case (ctrl.op)
            dpodc_pkg::UOP_DIV_Y, dpodc_pkg::UOP_DIV_YY: begin
               q_in = product[dpodc_pkg::RECIP_SHIFT +: dpodc_pkg::QUOT_W];
            end
            dpodc_pkg::UOP_CHECK: begin
               bad_in = bad_ff | date_bad;
               yy_in  = dpodc_pkg::YY_W'(year_sel) + 15'd400
                        - dpodc_pkg::YY_W'(month_sel <= 4'd2);
            end
            dpodc_pkg::UOP_SUM_A: begin
               acc_in = dpodc_pkg::SERIAL_W'(yy_ff) * 23'd365
                        + dpodc_pkg::SERIAL_W'(yy_ff >> 2);
            end
            dpodc_pkg::UOP_RANGE: begin
               lo_in = (serial_ff[0] > serial_ff[2]) ? serial_ff[0] : serial_ff[2];
               hi_in = (serial_ff[1] < serial_ff[3]) ? serial_ff[1] : serial_ff[3];
               ok_in = (serial_ff[1] >= serial_ff[0]) && (serial_ff[3] >= serial_ff[2]);
            end
            dpodc_pkg::UOP_COUNT: begin
               if (ok_ff && hi_ff >= lo_ff) begin
                  count_in = (span > (dpodc_pkg::SERIAL_W + 1)'(dpodc_pkg::COUNT_MAX))
                             ? dpodc_pkg::COUNT_MAX : span[dpodc_pkg::COUNT_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff <= 1'b0;
      end else begin
         bad_ff <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      yy_ff    <= yy_in;
      acc_ff   <= acc_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      ok_ff    <= ok_in;
      count_ff <= count_in;
      if (ctrl.valid && !ctrl.start && ctrl.op == dpodc_pkg::UOP_SUM_B) begin
         serial_ff[ctrl.date] <= serial_in;
      end
   end

   assign status.bad          = bad_ff;
   assign result.overlap_days = count_ff;
   assign result.bad_date     = bad_ff;

endmodule
